>>> hdl/todadj_pkg.sv
// constants, request codes and pipeline payload type for the time-of-day offset adjuster
`timescale 1ns / 1ps

package todadj_pkg;

  // field widths
  localparam int REQ_W    = 3;
  localparam int HOUR_W   = 5;
  localparam int MINSEC_W = 6;
  localparam int OFFSET_W = 17;
  localparam int REM_W    = 12;  // remainder below one hour, 0..3599

  // stream words, padded to whole bytes
  localparam int FIELDS_W = HOUR_W + 2 * MINSEC_W + OFFSET_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;
  localparam int TUSER_W  = REQ_W;

  // time constants
  localparam logic [OFFSET_W-1:0] DAY_SECONDS      = OFFSET_W'(24 * 60 * 60);
  localparam logic [OFFSET_W-1:0] HOUR_SECONDS     = OFFSET_W'(60 * 60);
  localparam logic [OFFSET_W-1:0] MINUTE_SECONDS   = OFFSET_W'(60);
  localparam logic [OFFSET_W-1:0] HOUR_DOWN_WRAP   = OFFSET_W'((23 * 60 * 60));
  localparam logic [OFFSET_W-1:0] MINUTE_DOWN_WRAP = OFFSET_W'((23 * 60 * 60) + (59 * 60));
  localparam logic [OFFSET_W-1:0] SECOND_DOWN_WRAP = OFFSET_W'((24 * 60 * 60) - 1);
  localparam logic [MINSEC_W-1:0] MAX_MINSEC       = MINSEC_W'(59);
  localparam logic [HOUR_W-1:0]   MAX_HOUR         = HOUR_W'(23);
  localparam logic [MINSEC_W-1:0] MINSEC_WRAP      = MINSEC_W'(60);
  localparam logic [HOUR_W-1:0]   HOUR_WRAP        = HOUR_W'(24);

  // reciprocal of 3600, exact for offsets below one day
  localparam int              HOUR_SHIFT = 29;
  localparam int              HOUR_REC_W = 18;
  localparam logic [HOUR_REC_W-1:0] HOUR_REC =
    HOUR_REC_W'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

  // reciprocal of 60, exact for remainders below one hour
  localparam int              MIN_SHIFT = 17;
  localparam int              MIN_REC_W = 12;
  localparam logic [MIN_REC_W-1:0] MIN_REC =
    MIN_REC_W'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

  // request codes
  localparam logic [REQ_W-1:0] REQ_QUERY       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HOUR_UP     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_HOUR_DOWN   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MINUTE_UP   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MINUTE_DOWN = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SECOND_UP   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SECOND_DOWN = 3'd6;
  localparam logic [REQ_W-1:0] REQ_LOAD        = 3'd7;

  // payload carried down the pipeline
  typedef struct packed {
    logic [OFFSET_W-1:0] off;
    logic [HOUR_W-1:0]   ch;
    logic [MINSEC_W-1:0] cm;
    logic [MINSEC_W-1:0] cs;
    logic [HOUR_W-1:0]   oh;
    logic [REM_W-1:0]    rem;
    logic [MINSEC_W-1:0] om;
    logic [MINSEC_W-1:0] os;
  } stage_t;

endpackage

>>> hdl/time_of_day_offset_adjuster_core.sv
// top level: offset update and display time pipeline of the time-of-day offset adjuster
`timescale 1ns / 1ps

// Time-of-day offset adjuster.
// The input stream carries one request per beat: tuser holds the request kind
// (query, hour/minute/second up or down, load offset), tdata the clock hour,
// minute and second and the offset to load. Every request gives exactly one
// result on the output stream: the displayed hour, minute and second and the
// offset in seconds after that request's update.
// The offset register is updated in the cycle a request is accepted, so a
// new request can enter on every cycle while s_axis_tready is high. The
// display time then goes through a six stage pipeline (update, hour split by
// reciprocal multiply, hour remainder, minute split, second remainder, carry
// adds), registered in each stage before m_axis_tvalid rises; sustained rate
// is one request per cycle while the receiver does not stall.
// Each stage moves on independently, so empty stages fill up while the
// receiver stalls; s_axis_tready falls only when all six stages hold
// requests and m_axis_tready is low.
// Reset (rst, synchronous) clears the offset to zero and empties the pipeline.
module time_of_day_offset_adjuster_core
  import todadj_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // clock_hour, clock_minute, clock_second, new_offset, zero pad
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [TUSER_W-1:0] s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // shown_hour, shown_minute, shown_second, offset_now, zero pad
  output logic [TDATA_W-1:0] m_axis_tdata
);

  localparam int NUM_STAGES = 6;

  // input field unpacking
  logic [REQ_W-1:0]    req_type;
  logic [HOUR_W-1:0]   clock_hour;
  logic [MINSEC_W-1:0] clock_minute;
  logic [MINSEC_W-1:0] clock_second;
  logic [OFFSET_W-1:0] new_offset;

  assign req_type     = s_axis_tuser;
  assign clock_hour   = s_axis_tdata[0 +: HOUR_W];
  assign clock_minute = s_axis_tdata[HOUR_W +: MINSEC_W];
  assign clock_second = s_axis_tdata[HOUR_W + MINSEC_W +: MINSEC_W];
  assign new_offset   = s_axis_tdata[HOUR_W + 2 * MINSEC_W +: OFFSET_W];

  // pipeline valid bits and per-stage ready
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] rdy;
  logic                  accept;

  always_comb begin
    rdy[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign accept        = s_axis_tvalid && rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // offset update for the request being accepted
  logic [OFFSET_W-1:0] offset_seconds;
  logic [OFFSET_W-1:0] offset_seconds_next;
  logic [OFFSET_W:0]   up_sum;
  logic [OFFSET_W-1:0] step_amt;
  logic [OFFSET_W-1:0] down_wrap;
  logic                step_up;
  logic                step_down;

  always_comb begin
    step_amt  = HOUR_SECONDS;
    down_wrap = HOUR_DOWN_WRAP;
    step_up   = 1'b0;
    step_down = 1'b0;
    case (req_type)
      REQ_HOUR_UP: begin
        step_up = 1'b1;
      end
      REQ_HOUR_DOWN: begin
        step_down = 1'b1;
      end
      REQ_MINUTE_UP: begin
        step_amt = MINUTE_SECONDS;
        step_up  = 1'b1;
      end
      REQ_MINUTE_DOWN: begin
        step_amt  = MINUTE_SECONDS;
        down_wrap = MINUTE_DOWN_WRAP;
        step_down = 1'b1;
      end
      REQ_SECOND_UP: begin
        step_amt = OFFSET_W'(1);
        step_up  = 1'b1;
      end
      REQ_SECOND_DOWN: begin
        step_amt  = OFFSET_W'(1);
        down_wrap = SECOND_DOWN_WRAP;
        step_down = 1'b1;
      end
      default: begin
      end
    endcase

    up_sum = {1'b0, offset_seconds} + {1'b0, step_amt};
    offset_seconds_next = offset_seconds;
    if (step_up) begin
      if (up_sum >= {1'b0, DAY_SECONDS}) begin
        offset_seconds_next = OFFSET_W'(up_sum - {1'b0, DAY_SECONDS});
      end else begin
        offset_seconds_next = up_sum[OFFSET_W-1:0];
      end
    end else if (step_down) begin
      if (offset_seconds < step_amt) begin
        offset_seconds_next = offset_seconds + down_wrap;
      end else begin
        offset_seconds_next = offset_seconds - step_amt;
      end
    end else if (req_type == REQ_LOAD) begin
      if (new_offset >= DAY_SECONDS) begin
        offset_seconds_next = new_offset - DAY_SECONDS;
      end else begin
        offset_seconds_next = new_offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_seconds <= '0;
    end else if (accept) begin
      offset_seconds <= offset_seconds_next;
    end
  end

  // stage 1: updated offset and clamped clock fields
  stage_t st1, st2, st3, st4, st5;
  stage_t st1_next;

  always_comb begin
    st1_next     = '0;
    st1_next.off = offset_seconds_next;
    st1_next.ch  = (clock_hour > MAX_HOUR) ? MAX_HOUR : clock_hour;
    st1_next.cm  = (clock_minute > MAX_MINSEC) ? MAX_MINSEC : clock_minute;
    st1_next.cs  = (clock_second > MAX_MINSEC) ? MAX_MINSEC : clock_second;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1 <= st1_next;
    end
  end

  // stage 2: offset hours by reciprocal multiply
  logic [OFFSET_W+HOUR_REC_W-1:0] hour_prod;
  stage_t                         st2_next;

  assign hour_prod = (OFFSET_W + HOUR_REC_W)'(st1.off) * (OFFSET_W + HOUR_REC_W)'(HOUR_REC);

  always_comb begin
    st2_next    = st1;
    st2_next.oh = hour_prod[HOUR_SHIFT +: HOUR_W];
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && valid[0]) begin
      st2 <= st2_next;
    end
  end

  // stage 3: seconds left below one hour
  logic [OFFSET_W-1:0] hour_part;
  stage_t              st3_next;

  assign hour_part = OFFSET_W'(st2.oh) * HOUR_SECONDS;

  always_comb begin
    st3_next     = st2;
    st3_next.rem = REM_W'(st2.off - hour_part);
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && valid[1]) begin
      st3 <= st3_next;
    end
  end

  // stage 4: offset minutes by reciprocal multiply
  logic [REM_W+MIN_REC_W-1:0] min_prod;
  stage_t                     st4_next;

  assign min_prod = (REM_W + MIN_REC_W)'(st3.rem) * (REM_W + MIN_REC_W)'(MIN_REC);

  always_comb begin
    st4_next    = st3;
    st4_next.om = min_prod[MIN_SHIFT +: MINSEC_W];
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && valid[2]) begin
      st4 <= st4_next;
    end
  end

  // stage 5: offset seconds
  logic [REM_W-1:0] min_part;
  stage_t           st5_next;

  assign min_part = REM_W'(st4.om) * REM_W'(MINUTE_SECONDS);

  always_comb begin
    st5_next    = st4;
    st5_next.os = MINSEC_W'(st4.rem - min_part);
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && valid[3]) begin
      st5 <= st5_next;
    end
  end

  // stage 6: add clock and offset with carries into the result register
  logic [MINSEC_W:0]   sec_sum;
  logic [MINSEC_W:0]   min_sum;
  logic [HOUR_W:0]     hour_sum;
  logic                sec_carry;
  logic                min_carry;
  logic [HOUR_W-1:0]   shown_hour_next;
  logic [MINSEC_W-1:0] shown_minute_next;
  logic [MINSEC_W-1:0] shown_second_next;

  always_comb begin
    sec_sum   = {1'b0, st5.cs} + {1'b0, st5.os};
    sec_carry = sec_sum > {1'b0, MAX_MINSEC};
    shown_second_next = sec_carry ? MINSEC_W'(sec_sum - {1'b0, MINSEC_WRAP})
                                  : sec_sum[MINSEC_W-1:0];

    min_sum   = {1'b0, st5.cm} + {1'b0, st5.om} + {{MINSEC_W{1'b0}}, sec_carry};
    min_carry = min_sum > {1'b0, MAX_MINSEC};
    shown_minute_next = min_carry ? MINSEC_W'(min_sum - {1'b0, MINSEC_WRAP})
                                  : min_sum[MINSEC_W-1:0];

    hour_sum = {1'b0, st5.ch} + {1'b0, st5.oh} + {{HOUR_W{1'b0}}, min_carry};
    shown_hour_next = (hour_sum > {1'b0, MAX_HOUR}) ? HOUR_W'(hour_sum - {1'b0, HOUR_WRAP})
                                                    : hour_sum[HOUR_W-1:0];
  end

  logic [HOUR_W-1:0]   shown_hour;
  logic [MINSEC_W-1:0] shown_minute;
  logic [MINSEC_W-1:0] shown_second;
  logic [OFFSET_W-1:0] offset_now;

  always_ff @(posedge clk) begin
    if (rdy[5] && valid[4]) begin
      shown_hour   <= shown_hour_next;
      shown_minute <= shown_minute_next;
      shown_second <= shown_second_next;
      offset_now   <= st5.off;
    end
  end

  // output packing
  assign m_axis_tvalid = valid[NUM_STAGES-1];
  assign m_axis_tdata  = {{PAD_W{1'b0}}, offset_now, shown_second, shown_minute, shown_hour};

`ifndef SYNTH
  // stored offset never reaches one day
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    offset_seconds < DAY_SECONDS)
    else $error("offset register out of range");

  // displayed fields stay inside their ranges
  a_shown_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (shown_hour <= MAX_HOUR && shown_minute <= MAX_MINSEC &&
                       shown_second <= MAX_MINSEC && offset_now < DAY_SECONDS))
    else $error("displayed time out of range");

  // back pressure only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (valid == '1 && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // an in-range load request sets the offset to the loaded value
  a_load: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_LOAD && new_offset < DAY_SECONDS)
      |=> offset_seconds == $past(new_offset))
    else $error("load request did not set the offset");

  // a query request leaves the offset alone
  a_query: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_QUERY) |=> $stable(offset_seconds))
    else $error("query request changed the offset");
`endif

endmodule

>>> tb/tb_time_of_day_offset_adjuster_core.sv
// testbench for the time-of-day offset adjuster: directed, random and back-pressure requests
`timescale 1ns / 1ps

module tb_time_of_day_offset_adjuster_core;
  import todadj_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int DRAIN_WAIT  = 20;

  // bit positions of the fields inside tdata
  localparam int MIN_LSB = HOUR_W;
  localparam int SEC_LSB = HOUR_W + MINSEC_W;
  localparam int OFF_LSB = HOUR_W + 2 * MINSEC_W;

  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [HOUR_W-1:0]   hour;
    logic [MINSEC_W-1:0] minute;
    logic [MINSEC_W-1:0] second;
    logic [OFFSET_W-1:0] load_value;
  } request_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINSEC_W-1:0] minute;
    logic [MINSEC_W-1:0] second;
    logic [OFFSET_W-1:0] offset;
  } display_t;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic [TUSER_W-1:0] s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;

  // predictor state and the displays still owed by the block
  int unsigned tracked_offset;
  display_t    display_q[$];
  int          mismatch_count;
  bit          no_idle;
  bit          long_hold;
  int          hold_left;
  int          quiet_cycles;

  time_of_day_offset_adjuster_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // update the tracked offset for one request and return the display it owes
  function automatic display_t apply_request(input request_t r);
    int unsigned ch, cm, cs, oh, om, os, dh, dm, ds;
    display_t d;
    ch = (r.hour > 23) ? 23 : r.hour;
    cm = (r.minute > 59) ? 59 : r.minute;
    cs = (r.second > 59) ? 59 : r.second;
    case (r.kind)
      REQ_HOUR_UP: begin
        tracked_offset = (tracked_offset + 3600) % 86400;
      end
      REQ_HOUR_DOWN: begin
        tracked_offset = (tracked_offset < 3600) ? tracked_offset + 82800
                                                 : tracked_offset - 3600;
      end
      REQ_MINUTE_UP: begin
        tracked_offset = (tracked_offset + 60) % 86400;
      end
      REQ_MINUTE_DOWN: begin
        tracked_offset = (tracked_offset < 60) ? tracked_offset + 86340
                                               : tracked_offset - 60;
      end
      REQ_SECOND_UP: begin
        tracked_offset = (tracked_offset + 1) % 86400;
      end
      REQ_SECOND_DOWN: begin
        tracked_offset = (tracked_offset == 0) ? 86399 : tracked_offset - 1;
      end
      REQ_LOAD: begin
        tracked_offset = (r.load_value >= 86400) ? r.load_value - 86400 : r.load_value;
      end
      default: begin
      end
    endcase
    oh = tracked_offset / 3600;
    om = (tracked_offset % 3600) / 60;
    os = tracked_offset % 60;
    ds = cs + os;
    if (ds > 59) begin
      ds -= 60;
      om += 1;
    end
    dm = cm + om;
    if (dm > 59) begin
      dm -= 60;
      oh += 1;
    end
    dh = (ch + oh) % 24;
    d.hour   = dh[HOUR_W-1:0];
    d.minute = dm[MINSEC_W-1:0];
    d.second = ds[MINSEC_W-1:0];
    d.offset = tracked_offset[OFFSET_W-1:0];
    return d;
  endfunction

  // offer one request, with random gaps ahead of it, and log its display once taken
  task automatic send_request(input request_t r);
    while (!no_idle && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({r.load_value, r.second, r.minute, r.hour});
    s_axis_tuser  <= r.kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    display_q.push_back(apply_request(r));
  endtask

  function automatic request_t make_request(input logic [REQ_W-1:0] kind,
                                            input int unsigned h, input int unsigned m,
                                            input int unsigned s, input int unsigned off);
    request_t r;
    r.kind       = kind;
    r.hour       = h[HOUR_W-1:0];
    r.minute     = m[MINSEC_W-1:0];
    r.second     = s[MINSEC_W-1:0];
    r.load_value = off[OFFSET_W-1:0];
    return r;
  endfunction

  // random request: mostly sane clock fields, loads often close to the day edges
  function automatic request_t random_request();
    request_t r;
    r.kind = REQ_W'($urandom_range(7));
    if ($urandom_range(4) == 0) begin
      r.hour   = HOUR_W'($urandom);
      r.minute = MINSEC_W'($urandom);
      r.second = MINSEC_W'($urandom);
    end else begin
      r.hour   = HOUR_W'($urandom_range(23));
      r.minute = MINSEC_W'($urandom_range(59));
      r.second = MINSEC_W'($urandom_range(59));
    end
    case ($urandom_range(3))
      0: r.load_value = OFFSET_W'($urandom_range(3700));
      1: r.load_value = OFFSET_W'($urandom_range(86399, 82700));
      default: r.load_value = OFFSET_W'($urandom);
    endcase
    return r;
  endfunction

  // day edges, every step direction and the clamped clock fields
  task automatic test_directed();
    send_request(make_request(REQ_QUERY, 0, 0, 0, 0));
    send_request(make_request(REQ_LOAD, 23, 59, 59, 86399));
    send_request(make_request(REQ_SECOND_UP, 23, 59, 59, 0));
    send_request(make_request(REQ_SECOND_DOWN, 0, 0, 0, 0));
    send_request(make_request(REQ_SECOND_UP, 12, 30, 30, 0));
    send_request(make_request(REQ_LOAD, 5, 5, 5, 100));
    send_request(make_request(REQ_HOUR_DOWN, 1, 2, 3, 0));
    send_request(make_request(REQ_LOAD, 5, 5, 5, 30));
    send_request(make_request(REQ_MINUTE_DOWN, 23, 59, 59, 0));
    send_request(make_request(REQ_LOAD, 0, 0, 0, 86000));
    send_request(make_request(REQ_HOUR_UP, 23, 0, 0, 0));
    send_request(make_request(REQ_LOAD, 0, 0, 0, 86399));
    send_request(make_request(REQ_MINUTE_UP, 0, 0, 59, 0));
    send_request(make_request(REQ_MINUTE_DOWN, 10, 0, 0, 0));
    send_request(make_request(REQ_HOUR_UP, 10, 0, 0, 0));
    send_request(make_request(REQ_LOAD, 0, 0, 0, 86400));
    send_request(make_request(REQ_LOAD, 7, 7, 7, 131071));
    send_request(make_request(REQ_QUERY, 31, 63, 63, 131071));
    send_request(make_request(REQ_QUERY, 24, 60, 60, 0));
    send_request(make_request(REQ_LOAD, 23, 59, 59, 86399));
    send_request(make_request(REQ_QUERY, 31, 63, 63, 0));
  endtask

  // back to back requests on both sides
  task automatic test_full_rate();
    no_idle = 1'b1;
    repeat (100) send_request(random_request());
    no_idle = 1'b0;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_back_pressure();
    long_hold = 1'b1;
    no_idle   = 1'b1;
    repeat (40) send_request(random_request());
    no_idle   = 1'b0;
  endtask

  task automatic test_random();
    repeat (350) send_request(random_request());
  endtask

  // receiver: random ready, or a long hold counted here
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
        if (hold_left == 0) long_hold = 1'b0;
      end else if (long_hold) begin
        m_axis_tready <= 1'b0;
        hold_left = LONG_HOLD;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 34);
      end
    end
  end

  // result check against the oldest owed display
  always @(posedge clk) begin
    display_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hour   = m_axis_tdata[MIN_LSB-1:0];
      got.minute = m_axis_tdata[SEC_LSB-1:MIN_LSB];
      got.second = m_axis_tdata[OFF_LSB-1:SEC_LSB];
      got.offset = m_axis_tdata[OFF_LSB+OFFSET_W-1:OFF_LSB];
      if (display_q.size() == 0) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = display_q.pop_front();
        if (got.hour !== want.hour) begin
          $error("shown_hour expected %0d got %0d", want.hour, got.hour);
          mismatch_count++;
        end
        if (got.minute !== want.minute) begin
          $error("shown_minute expected %0d got %0d", want.minute, got.minute);
          mismatch_count++;
        end
        if (got.second !== want.second) begin
          $error("shown_second expected %0d got %0d", want.second, got.second);
          mismatch_count++;
        end
        if (got.offset !== want.offset) begin
          $error("offset_now expected %0d got %0d", want.offset, got.offset);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** time_of_day_offset_adjuster_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    tracked_offset = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    no_idle        = 1'b0;
    long_hold      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_rate();
    test_back_pressure();
    test_random();

    s_axis_tvalid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** time_of_day_offset_adjuster_core: PASSED **");
    end else begin
      $display("** time_of_day_offset_adjuster_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/todadj_pkg.sv
hdl/time_of_day_offset_adjuster_core.sv
tb/tb_time_of_day_offset_adjuster_core.sv
